>>> src/lofsw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lofsw_pkg
// shared types and constants for the letter order block
// ----------------------------------------------------------------------------
package lofsw_pkg;

    localparam int MAX_WORD_LEN_DEF = 128;
    localparam int NODES            = 27;
    localparam int NODE_W           = 5;
    localparam int LETTER_W         = 5;
    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
    localparam logic [NODE_W-1:0]   END_NODE    = 5'd0;
    localparam logic [NODE_W-1:0]   NODE_LIMIT  = 5'd27;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_ROOT,
        S_WALK,
        S_EMIT,
        S_FAIL
    } state_t;

endpackage
`default_nettype wire

>>> src/lofsw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lofsw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lofsw_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> src/letter_order_from_sorted_words_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// letter_order_from_sorted_words_top
// compares each word with the previous one to collect letter precedence
// edges, then runs a depth-first topological sort at list end
// ----------------------------------------------------------------------------
// per letter beat: word store read, then compare and write
// list end: depth-first walk, one edge bit tested per cycle
// output: 26 order beats or one impossible beat, held while out_stall is high
// input: stalled until the last letter beat is compared, and during the walk and output
// reset: asynchronous, clears all control state and the edge matrix
// ----------------------------------------------------------------------------
module letter_order_from_sorted_words_top
    import lofsw_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [LETTER_W-1:0] letter,
    input  wire logic                word_end,
    input  wire logic                list_end,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [LETTER_W-1:0] order_letter,
    output logic                     impossible,
    output logic                     last
);

    localparam int PW        = $clog2(MAX_WORD_LEN + 1);
    localparam int AW        = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int RAM_DEPTH = 2 ** (AW + 1);
    localparam logic [PW-1:0] LEN_LIMIT = PW'(MAX_WORD_LEN);

    state_t state_reg, state_next;

    logic [LETTER_W-1:0] let_reg;
    logic                wend_reg, lend_reg;
    logic                sel_reg, sel_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       plen_reg, plen_next;
    logic                first_reg, first_next;
    logic                peq_reg, peq_next;
    logic                fail_reg, fail_next;

    logic [NODES-1:0]    edge_rows_reg [NODES];
    logic [NODES-1:0]    edge_rows_next [NODES];
    logic [NODES-1:0]    gray_reg, gray_next;
    logic [NODES-1:0]    black_reg, black_next;
    logic [NODE_W-1:0]   stk_node_reg [NODES];
    logic [NODE_W-1:0]   stk_node_next [NODES];
    logic [NODE_W-1:0]   stk_nxt_reg [NODES];
    logic [NODE_W-1:0]   stk_nxt_next [NODES];
    logic [NODE_W-1:0]   order_reg [NODES];
    logic [NODE_W-1:0]   order_next [NODES];
    logic [NODE_W-1:0]   root_reg, root_next;
    logic [NODE_W-1:0]   depth_reg, depth_next;
    logic [NODE_W-1:0]   done_reg, done_next;
    logic [NODE_W-1:0]   emit_k_reg, emit_k_next;

    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] out_letter_reg, out_letter_next;
    logic                out_imp_reg, out_imp_next;
    logic                out_last_reg, out_last_next;

    logic                in_acc;
    logic [LETTER_W-1:0] let_clamp;
    logic [LETTER_W-1:0] rd_data;
    logic                wr_en;
    logic [AW:0]         wr_addr, rd_addr;

    logic                in_rng, cmp_act, beyond, add_e, peq_after, any_end, fail_now;
    logic [PW-1:0]       pos_after;
    logic [NODE_W-1:0]   e_from, e_to;

    logic [NODE_W-1:0]   top, cur_v, cur_i;
    logic                at_end, has_e, tgt_gray, tgt_open;

    logic [NODE_W-1:0]   ord_k;
    logic                is_last, load_ok, emit_load;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign let_clamp = (letter > LAST_LETTER) ? LAST_LETTER : letter;

    // word store: two buffers, current and previous word
    assign rd_addr = {~sel_reg, pos_reg[AW-1:0]};
    assign wr_addr = {sel_reg, pos_reg[AW-1:0]};
    assign wr_en   = (state_reg == S_CMP) && in_rng;

    lofsw_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (RAM_DEPTH)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (let_reg),
        .rd_en   (in_acc),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // compare step
    assign in_rng    = (pos_reg < LEN_LIMIT);
    assign cmp_act   = in_rng && !first_reg && peq_reg;
    assign beyond    = (pos_reg >= plen_reg);
    assign add_e     = cmp_act && (beyond || (rd_data != let_reg));
    assign e_from    = beyond ? END_NODE : (rd_data + NODE_W'(1));
    assign e_to      = let_reg + NODE_W'(1);
    assign peq_after = peq_reg && !add_e;
    assign pos_after = in_rng ? (pos_reg + PW'(1)) : pos_reg;
    assign any_end   = wend_reg || lend_reg;
    assign fail_now  = fail_reg
                       || (!first_reg && peq_after && (pos_after < plen_reg));

    // walk step
    assign top      = depth_reg - NODE_W'(1);
    assign cur_v    = stk_node_reg[top];
    assign cur_i    = stk_nxt_reg[top];
    assign at_end   = (cur_i == NODE_LIMIT);
    assign has_e    = !at_end && edge_rows_reg[cur_v][cur_i];
    assign tgt_gray = gray_reg[cur_i] && !black_reg[cur_i];
    assign tgt_open = !gray_reg[cur_i];

    // emit step
    assign ord_k     = order_reg[emit_k_reg];
    assign is_last   = (emit_k_reg == '0)
                       || ((emit_k_reg == NODE_W'(1)) && (order_reg[0] == END_NODE));
    assign load_ok   = !out_valid_reg || !out_stall;
    assign emit_load = (state_reg == S_EMIT) && load_ok && (ord_k != END_NODE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (any_end && lend_reg)
                begin
                    state_next = fail_now ? S_FAIL : S_ROOT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (root_reg == NODE_LIMIT)
                begin
                    state_next = S_EMIT;
                end
                else if (!gray_reg[root_reg])
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (at_end)
                begin
                    if (depth_reg == NODE_W'(1))
                    begin
                        state_next = S_ROOT;
                    end
                end
                else if (has_e && tgt_gray)
                begin
                    state_next = S_FAIL;
                end
            end
            S_EMIT:
            begin
                if (emit_load && is_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sel_next        = sel_reg;
        pos_next        = pos_reg;
        plen_next       = plen_reg;
        first_next      = first_reg;
        peq_next        = peq_reg;
        fail_next       = fail_reg;
        edge_rows_next  = edge_rows_reg;
        gray_next       = gray_reg;
        black_next      = black_reg;
        stk_node_next   = stk_node_reg;
        stk_nxt_next    = stk_nxt_reg;
        order_next      = order_reg;
        root_next       = root_reg;
        depth_next      = depth_reg;
        done_next       = done_reg;
        emit_k_next     = emit_k_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_letter_next = out_letter_reg;
        out_imp_next    = out_imp_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_CMP:
            begin
                if (add_e)
                begin
                    edge_rows_next[e_from][e_to] = 1'b1;
                end
                if (cmp_act)
                begin
                    peq_next = peq_after;
                end
                pos_next = pos_after;
                if (any_end)
                begin
                    fail_next  = fail_now;
                    plen_next  = pos_after;
                    sel_next   = ~sel_reg;
                    pos_next   = '0;
                    first_next = 1'b0;
                    peq_next   = 1'b1;
                end
            end
            S_ROOT:
            begin
                if (root_reg == NODE_LIMIT)
                begin
                    emit_k_next = NODE_LIMIT - NODE_W'(1);
                end
                else if (!gray_reg[root_reg])
                begin
                    gray_next[root_reg] = 1'b1;
                    stk_node_next[0]    = root_reg;
                    stk_nxt_next[0]     = '0;
                    depth_next          = NODE_W'(1);
                end
                else
                begin
                    root_next = root_reg + NODE_W'(1);
                end
            end
            S_WALK:
            begin
                if (at_end)
                begin
                    black_next[cur_v]   = 1'b1;
                    order_next[done_reg] = cur_v;
                    done_next           = done_reg + NODE_W'(1);
                    depth_next          = top;
                end
                else
                begin
                    stk_nxt_next[top] = cur_i + NODE_W'(1);
                    if (has_e && tgt_open)
                    begin
                        gray_next[cur_i]         = 1'b1;
                        stk_node_next[depth_reg] = cur_i;
                        stk_nxt_next[depth_reg]  = '0;
                        depth_next               = depth_reg + NODE_W'(1);
                    end
                end
            end
            S_EMIT:
            begin
                if (load_ok)
                begin
                    if (ord_k != END_NODE)
                    begin
                        out_valid_next  = 1'b1;
                        out_letter_next = ord_k - NODE_W'(1);
                        out_imp_next    = 1'b0;
                        out_last_next   = is_last;
                    end
                    emit_k_next = emit_k_reg - NODE_W'(1);
                end
            end
            S_FAIL:
            begin
                if (load_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = '0;
                    out_imp_next    = 1'b1;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // end of run: compare and walk state and the edge matrix cleared as at reset
        if (((state_reg == S_EMIT) && emit_load && is_last)
            || ((state_reg == S_FAIL) && load_ok))
        begin
            sel_next   = 1'b0;
            pos_next   = '0;
            plen_next  = '0;
            first_next = 1'b1;
            peq_next   = 1'b1;
            fail_next  = 1'b0;
            gray_next  = '0;
            black_next = '0;
            root_next  = '0;
            depth_next = '0;
            done_next  = '0;
            for (int n = 0; n < NODES; n++)
            begin
                edge_rows_next[n] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            pos_reg       <= '0;
            plen_reg      <= '0;
            first_reg     <= 1'b1;
            peq_reg       <= 1'b1;
            fail_reg      <= 1'b0;
            gray_reg      <= '0;
            black_reg     <= '0;
            root_reg      <= '0;
            depth_reg     <= '0;
            done_reg      <= '0;
            emit_k_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < NODES; n++)
            begin
                edge_rows_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            pos_reg       <= pos_next;
            plen_reg      <= plen_next;
            first_reg     <= first_next;
            peq_reg       <= peq_next;
            fail_reg      <= fail_next;
            gray_reg      <= gray_next;
            black_reg     <= black_next;
            root_reg      <= root_next;
            depth_reg     <= depth_next;
            done_reg      <= done_next;
            emit_k_reg    <= emit_k_next;
            out_valid_reg <= out_valid_next;
            edge_rows_reg <= edge_rows_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            let_reg  <= let_clamp;
            wend_reg <= word_end;
            lend_reg <= list_end;
        end
        stk_node_reg   <= stk_node_next;
        stk_nxt_reg    <= stk_nxt_next;
        order_reg      <= order_next;
        out_letter_reg <= out_letter_next;
        out_imp_reg    <= out_imp_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign order_letter = out_letter_reg;
    assign impossible   = out_imp_reg;
    assign last         = out_last_reg;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter order testbench
// streams word lists into the block and checks each derived letter order,
// or the impossible beat, against a predictor that tracks precedence edges
// between words and runs its own depth-first topological sort at list end
// ----------------------------------------------------------------------------
module tb
    import lofsw_pkg::*;
();

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                word_end;
        logic                list_end;
    } letter_beat_t;

    typedef struct packed {
        logic [LETTER_W-1:0] order_letter;
        logic                impossible;
        logic                last;
    } order_beat_t;

    localparam int WORD_CAP    = MAX_WORD_LEN_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [LETTER_W-1:0] letter;
    logic                word_end;
    logic                list_end;
    logic                out_valid;
    logic                out_stall;
    logic [LETTER_W-1:0] order_letter;
    logic                impossible;
    logic                last;

    letter_beat_t pending_beats[$];
    order_beat_t  expected_orders[$];
    int           errors;
    int           cycles;
    int           lists_sent;
    int           beats_sent;
    int           orders_seen;
    int           impossible_seen;
    bit           hold_sender;
    bit           long_hold_req;
    int           send_gap;
    int           recv_gap;
    int           recv_hold;

    // predictor state
    logic [4:0]  prev_word[WORD_CAP];
    logic [4:0]  cur_word[WORD_CAP];
    int          prev_len;
    int          word_pos;
    bit          first_word_p;
    bit          prefix_eq_p;
    bit          failed_p;
    logic [26:0] succ_rows[27];

    letter_order_from_sorted_words_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .letter(letter), .word_end(word_end), .list_end(list_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .order_letter(order_letter), .impossible(impossible), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_dictionary();
        prev_len = 0;
        word_pos = 0;
        first_word_p = 1'b1;
        prefix_eq_p = 1'b1;
        failed_p = 1'b0;
        for (int n = 0; n < 27; n++)
            succ_rows[n] = '0;
    endfunction

    function automatic bit sort_letters(output logic [4:0] post[27]);
        logic [1:0] color[27];
        logic [4:0] stk_node[27];
        logic [5:0] stk_next[27];
        int         done;
        int         depth;
        int         v;
        int         i;
        done = 0;
        for (int n = 0; n < 27; n++)
        begin
            color[n] = 2'd0;
            post[n] = '0;
        end
        for (int root = 0; root < 27; root++)
        begin
            if (color[root] != 0)
                continue;
            color[root] = 2'd1;
            stk_node[0] = root[4:0];
            stk_next[0] = '0;
            depth = 1;
            while (depth > 0)
            begin
                v = stk_node[depth-1];
                i = stk_next[depth-1];
                while (i < 27 && !succ_rows[v][i])
                    i++;
                if (i < 27)
                begin
                    stk_next[depth-1] = 6'(i + 1);
                    if (color[i] == 1)
                        return 1'b0;
                    if (color[i] == 0 && depth < 27)
                    begin
                        color[i] = 2'd1;
                        stk_node[depth] = i[4:0];
                        stk_next[depth] = '0;
                        depth++;
                    end
                end
                else
                begin
                    color[v] = 2'd2;
                    if (done < 27)
                    begin
                        post[done] = v[4:0];
                        done++;
                    end
                    depth--;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_order(letter_beat_t b);
        logic [4:0]  l;
        logic [4:0]  post[27];
        order_beat_t r;
        int          cnt;
        l = (b.letter > LAST_LETTER) ? LAST_LETTER : b.letter;
        if (word_pos < WORD_CAP)
        begin
            if (!first_word_p && prefix_eq_p)
            begin
                if (word_pos >= prev_len)
                begin
                    succ_rows[0][l+1] = 1'b1;
                    prefix_eq_p = 1'b0;
                end
                else if (prev_word[word_pos] != l)
                begin
                    succ_rows[prev_word[word_pos]+1][l+1] = 1'b1;
                    prefix_eq_p = 1'b0;
                end
            end
            cur_word[word_pos] = l;
            word_pos++;
        end
        if (!(b.word_end || b.list_end))
            return;
        if (!first_word_p && prefix_eq_p && word_pos < prev_len)
            failed_p = 1'b1;
        prev_len = word_pos;
        prev_word = cur_word;
        word_pos = 0;
        first_word_p = 1'b0;
        prefix_eq_p = 1'b1;
        if (!b.list_end)
            return;
        if (!failed_p && sort_letters(post))
        begin
            cnt = 0;
            for (int k = 26; k >= 0; k--)
            begin
                if (post[k] == END_NODE)
                    continue;
                r.order_letter = 5'(post[k] - 1);
                r.impossible = 1'b0;
                cnt++;
                r.last = (cnt == 26);
                expected_orders = {expected_orders, r};
            end
        end
        else
        begin
            r.order_letter = '0;
            r.impossible = 1'b1;
            r.last = 1'b1;
            expected_orders = {expected_orders, r};
        end
        clear_dictionary();
    endfunction

    // queue one word of a list; the word is given as its letters
    task automatic queue_word(logic [4:0] w[$], bit end_of_list, bit drop_word_end);
        letter_beat_t b;
        for (int i = 0; i < w.size(); i++)
        begin
            b.letter = w[i];
            b.word_end = (i == w.size() - 1) && !(drop_word_end && end_of_list);
            b.list_end = (i == w.size() - 1) && end_of_list;
            pending_beats = {pending_beats, b};
        end
    endtask

    task automatic queue_random_list(int mode);
        logic [4:0] alpha[26];
        logic [4:0] w[$];
        logic [4:0] p[$];
        int         nwords;
        int         len;
        int         rank;
        int         j;
        for (int i = 0; i < 26; i++)
            alpha[i] = 5'(i);
        alpha.shuffle();
        nwords = $urandom_range(1, 8);
        p = {};
        for (int n = 0; n < nwords; n++)
        begin
            w = {};
            len = $urandom_range(1, 6);
            if (mode == 0 && n > 0)
            begin
                // sorted under the hidden alphabet: share a prefix, then go later
                j = $urandom_range(0, p.size());
                for (int k = 0; k < j && k < p.size(); k++)
                    w = {w, p[k]};
                if (j < p.size())
                begin
                    rank = 0;
                    for (int k = 0; k < 26; k++)
                        if (alpha[k] == p[j])
                            rank = k;
                    if (rank < 25)
                        w = {w, alpha[$urandom_range(rank + 1, 25)]};
                    else
                        w = p;
                end
                while (w.size() < len + j && $urandom_range(0, 1))
                    w = {w, alpha[$urandom_range(0, 25)]};
                if (w.size() == 0)
                    w = {w, alpha[0]};
            end
            else
            begin
                for (int k = 0; k < len; k++)
                    w = {w, 5'(mode == 2 ? $urandom_range(0, 31) : $urandom_range(0, 25))};
            end
            queue_word(w, n == nwords - 1, $urandom_range(0, 7) == 0);
            p = w;
        end
        lists_sent++;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || expected_orders.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            letter <= '0;
            word_end <= 1'b0;
            list_end <= 1'b0;
            send_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                predict_order({letter, word_end, list_end});
                beats_sent++;
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0 && !hold_sender)
            begin
                {letter, word_end, list_end} <= pending_beats.pop_front();
                in_valid <= 1'b1;
                case ($urandom_range(0, 19))
                    0, 1, 2: send_gap <= $urandom_range(1, 3);
                    3:       send_gap <= $urandom_range(10, 40);
                    default: send_gap <= 0;
                endcase
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        order_beat_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            recv_hold <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_orders.size() == 0)
                begin
                    $error("order beat with no expectation: letter %0d", order_letter);
                    errors++;
                end
                else
                begin
                    e = expected_orders.pop_front();
                    if (order_letter !== e.order_letter)
                    begin
                        $error("order_letter expected %0d actual %0d", e.order_letter, order_letter);
                        errors++;
                    end
                    if (impossible !== e.impossible)
                    begin
                        $error("impossible expected %0d actual %0d", e.impossible, impossible);
                        errors++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last expected %0d actual %0d", e.last, last);
                        errors++;
                    end
                    if (e.impossible)
                        impossible_seen++;
                    else
                        orders_seen++;
                end
            end
            if (long_hold_req && recv_hold == 0)
            begin
                recv_hold <= 3000;
                out_stall <= 1'b1;
            end
            else if (recv_hold > 1)
                recv_hold <= recv_hold - 1;
            else if (recv_hold == 1)
            begin
                recv_hold <= 0;
                out_stall <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                case ($urandom_range(0, 19))
                    0, 1, 2: recv_gap <= $urandom_range(1, 3);
                    3:       recv_gap <= $urandom_range(8, 30);
                    default: recv_gap <= 0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d beats pending", expected_orders.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [4:0] w[$];
        errors = 0;
        cycles = 0;
        lists_sent = 0;
        beats_sent = 0;
        orders_seen = 0;
        impossible_seen = 0;
        hold_sender = 1'b0;
        long_hold_req = 1'b0;
        clear_dictionary();
        rst_n = 1'b0;
        in_valid = 1'b0;
        letter = '0;
        word_end = 1'b0;
        list_end = 1'b0;
        out_stall = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // single word list
        w = {5'd0};
        queue_word(w, 1, 0);
        // z before a, and out of range letter folded to z
        w = {5'd25};
        queue_word(w, 0, 0);
        w = {5'd31, 5'd0};
        queue_word(w, 0, 0);
        w = {5'd0};
        queue_word(w, 1, 1);
        // proper prefix after longer word
        w = {5'd1, 5'd2};
        queue_word(w, 0, 0);
        w = {5'd1};
        queue_word(w, 1, 0);
        // cycle a<b<a
        w = {5'd0};
        queue_word(w, 0, 0);
        w = {5'd1};
        queue_word(w, 0, 0);
        w = {5'd0};
        queue_word(w, 1, 0);
        lists_sent += 4;
        wait_drained();

        // long word past the store limit, then a copy that differs only past the limit
        w = {};
        for (int i = 0; i < WORD_CAP + 4; i++)
            w = {w, 5'(i % 26)};
        queue_word(w, 0, 0);
        w[WORD_CAP + 1] = 5'd3;
        queue_word(w, 1, 0);
        lists_sent++;
        wait_drained();

        // long receiver hold while lists keep coming
        long_hold_req = 1'b1;
        for (int n = 0; n < 4; n++)
            queue_random_list(0);
        wait (recv_hold != 0);
        long_hold_req = 1'b0;
        wait_drained();

        while (beats_sent < 420)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: queue_random_list(0);
                6, 7, 8:          queue_random_list(1);
                default:          queue_random_list(2);
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                wait_drained();
                hold_sender = 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
                hold_sender = 1'b0;
            end
            while (pending_beats.size() > 40)
                @(posedge clk);
        end
        wait_drained();
        repeat (800) @(posedge clk);

        $display("covered %0d lists over %0d letter beats", lists_sent, beats_sent);
        $display("%0d order beats and %0d impossible answers checked", orders_seen,
                 impossible_seen);
        if (errors == 0 && expected_orders.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
